FILE: rtl/snp_pkg.sv
// Shared types, constants and the forged header table for the NoC snoop and inject block.
// No dependencies; every other file in rtl/ imports this package.
package snp_pkg;

  localparam int FlitW        = 16;
  localparam int HeaderFlits  = 26;
  localparam int RxBufDepth   = 128;
  localparam int PayloadFlits = 3;
  localparam int RewindFlits  = 3;
  localparam int LatchCount   = 14;
  localparam int CfgIndexW    = 3;
  localparam int CfgDataW     = 32;

  localparam logic [FlitW-1:0] SizeSkipMin = 16'h000B;
  localparam logic [FlitW-1:0] HdrCtrlWord = 16'h0100;
  localparam logic [FlitW-1:0] HdrSizeWord = 16'(11 + 2);
  localparam logic [FlitW-1:0] HdrMarkWord = 16'h0002;

  // Positions of the received header words that the receiver keeps.
  localparam logic [6:0] RxPosRoute   = 7'd3;
  localparam logic [6:0] RxPosSize    = 7'd5;
  localparam logic [6:0] RxPosService = 7'd7;
  localparam logic [6:0] RxPosTask    = 7'd9;
  localparam logic [6:0] RxPosPeriph  = 7'd11;

  // Positions of the nonzero words in a forged header.
  localparam logic [5:0] TxPosRouteA  = 6'd0;
  localparam logic [5:0] TxPosCtrlA   = 6'd1;
  localparam logic [5:0] TxPosRouteB  = 6'd2;
  localparam logic [5:0] TxPosCtrlB   = 6'd3;
  localparam logic [5:0] TxPosSize    = 6'd5;
  localparam logic [5:0] TxPosService = 6'd7;
  localparam logic [5:0] TxPosTask    = 6'd9;
  localparam logic [5:0] TxPosPeriph  = 6'd11;
  localparam logic [5:0] TxPosRoute   = 6'd13;
  localparam logic [5:0] TxPosMark    = 6'd19;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_WINDOW_START    = 3'd0,
    CFG_WINDOW_END      = 3'd1,
    CFG_GAP_TICKS       = 3'd2,
    CFG_TRIGGER_SERVICE = 3'd3,
    CFG_FORGED_SERVICE  = 3'd4,
    CFG_FORGED_ROUTE    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [31:0]      window_start;
    logic [31:0]      window_end;
    logic [7:0]       gap_ticks;
    logic [FlitW-1:0] trigger_service;
    logic [FlitW-1:0] forged_service;
    logic [FlitW-1:0] forged_route;
  } cfg_t;

  typedef struct packed {
    logic [FlitW-1:0] route;
    logic [FlitW-1:0] tsk;
    logic [FlitW-1:0] periph;
  } lat_t;

  typedef struct packed {
    logic             path_request;
    logic             tx_last;
    logic [FlitW-1:0] tx_flit;
    logic             tx_valid;
  } res_t;

  function automatic logic [FlitW-1:0] header_flit(
    input logic [5:0]       idx,
    input logic [FlitW-1:0] froute,
    input logic [FlitW-1:0] fsvc,
    input logic [FlitW-1:0] tsk,
    input logic [FlitW-1:0] periph,
    input logic [FlitW-1:0] route
  );
    logic [FlitW-1:0] w;
    case (idx)
      TxPosRouteA, TxPosRouteB: w = froute;
      TxPosCtrlA, TxPosCtrlB:   w = HdrCtrlWord;
      TxPosSize:                w = HdrSizeWord;
      TxPosService:             w = fsvc;
      TxPosTask:                w = tsk;
      TxPosPeriph:              w = periph;
      TxPosRoute:               w = route;
      TxPosMark:                w = HdrMarkWord;
      default:                  w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [FlitW-1:0] payload_flit(input logic [5:0] k);
    return FlitW'(HeaderFlits) + FlitW'(k);
  endfunction

endpackage

FILE: rtl/noc_packet_snoop_and_inject.sv
// NoC port snooper and packet forger: one input word is one router tick, one result word each.
// A result word passes through the input register and then the two-word result buffer before it
// is offered. Throughput: one word per cycle while the result buffer has room.
// Reset (synchronous, active low) clears the receive and send sequencers, the tick counter,
// the path request flag and the buffers, and loads the configuration defaults.
// Depends on snp_pkg, snp_rx, snp_tx and snp_skid.
module noc_packet_snoop_and_inject (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // rx_valid [0], rx_flit [16:1], credit_in [17], zero fill [23:18]
  input  logic [23:0]                   in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tx_valid [0], tx_flit [16:1], credit_out [17], path_request [18], zero fill [23:19]
  output logic [23:0]                   out_tdata,
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [snp_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [snp_pkg::CfgDataW-1:0]  cfg_wdata
);
  import snp_pkg::*;

  cfg_t             cfg_r;
  logic             ival_r;
  logic             rx_valid_r, rx_last_r, credit_r;
  logic [FlitW-1:0] rx_flit_r;
  logic             step, buf_ready;
  lat_t             lat;
  logic             tx_valid_nxt, tx_last_nxt, req_nxt;
  logic [FlitW-1:0] tx_flit_nxt;
  res_t             res_nxt, res_out;

  assign step      = ival_r && buf_ready;
  assign in_tready = !ival_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_start    <= 32'd33500;
      cfg_r.window_end      <= 32'd48000;
      cfg_r.gap_ticks       <= 8'd220;
      cfg_r.trigger_service <= 16'h0300;
      cfg_r.forged_service  <= 16'h0025;
      cfg_r.forged_route    <= 16'h0083;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_WINDOW_START:    cfg_r.window_start    <= cfg_wdata;
        CFG_WINDOW_END:      cfg_r.window_end      <= cfg_wdata;
        CFG_GAP_TICKS:       cfg_r.gap_ticks       <= cfg_wdata[7:0];
        CFG_TRIGGER_SERVICE: cfg_r.trigger_service <= cfg_wdata[FlitW-1:0];
        CFG_FORGED_SERVICE:  cfg_r.forged_service  <= cfg_wdata[FlitW-1:0];
        CFG_FORGED_ROUTE:    cfg_r.forged_route    <= cfg_wdata[FlitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ival_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      ival_r <= 1'b1;
    end else if (step) begin
      ival_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      rx_valid_r <= in_tdata[0];
      rx_flit_r  <= in_tdata[FlitW:1];
      credit_r   <= in_tdata[FlitW+1];
      rx_last_r  <= in_tlast;
    end
  end

  snp_rx u_rx (
    .clk               (clk),
    .rst_n             (rst_n),
    .step_i            (step),
    .rx_valid_i        (rx_valid_r),
    .rx_flit_i         (rx_flit_r),
    .rx_last_i         (rx_last_r),
    .trigger_service_i (cfg_r.trigger_service),
    .lat_o             (lat),
    .req_nxt_o         (req_nxt)
  );

  snp_tx u_tx (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (step),
    .credit_i    (credit_r),
    .cfg_i       (cfg_r),
    .lat_i       (lat),
    .valid_nxt_o (tx_valid_nxt),
    .flit_nxt_o  (tx_flit_nxt),
    .last_nxt_o  (tx_last_nxt)
  );

  assign res_nxt = {req_nxt, tx_last_nxt, tx_flit_nxt, tx_valid_nxt};

  snp_skid u_skid (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (step),
    .push_data_i (res_nxt),
    .ready_o     (buf_ready),
    .out_valid_o (out_tvalid),
    .out_data_o  (res_out),
    .out_ready_i (out_tready)
  );

  assign out_tdata = {5'd0, res_out.path_request, 1'b1, res_out.tx_flit, res_out.tx_valid};
  assign out_tlast = res_out.tx_last;

endmodule

FILE: rtl/snp_rx.sv
// Receive side: flit counter, header word capture, payload skip and the sticky path request.
// Depends on snp_pkg.
module snp_rx (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_i,
  input  logic                       rx_valid_i,
  input  logic [snp_pkg::FlitW-1:0]  rx_flit_i,
  input  logic                       rx_last_i,
  input  logic [snp_pkg::FlitW-1:0]  trigger_service_i,
  output snp_pkg::lat_t              lat_o,
  output logic                       req_nxt_o
);
  import snp_pkg::*;

  typedef enum logic [2:0] {
    RX_IDLE    = 3'd0,
    RX_RECEIVE = 3'd1,
    RX_WAIT    = 3'd2,
    RX_SERVICE = 3'd3,
    RX_PAYLOAD = 3'd4
  } rx_phase_t;

  localparam logic [7:0] IdxMask = 8'(RxBufDepth - 1);

  rx_phase_t        phase_r, phase_nxt;
  logic [7:0]       count_r, count_nxt, cnt_inc;
  logic             req_r, req_nxt;
  logic [FlitW-1:0] sh_route_r, sh_size_r, sh_service_r, sh_task_r, sh_periph_r;
  logic [FlitW-1:0] lat_route_r, lat_size_r, lat_service_r, lat_task_r, lat_periph_r;
  logic [FlitW-1:0] size_chk;
  logic [6:0]       idx;
  logic             store_en, latch_en;

  assign cnt_inc = count_r + 8'd1;
  assign idx     = 7'(count_r & IdxMask);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    req_nxt   = req_r;
    store_en  = 1'b0;
    latch_en  = 1'b0;
    size_chk  = lat_size_r;
    case (phase_r)
      RX_RECEIVE: begin
        if (rx_valid_i) begin
          store_en  = 1'b1;
          count_nxt = cnt_inc;
          latch_en  = (cnt_inc == 8'(LatchCount));
          size_chk  = latch_en ? sh_size_r : lat_size_r;
          if (cnt_inc == 8'(HeaderFlits) && size_chk > SizeSkipMin) begin
            phase_nxt = RX_PAYLOAD;
            count_nxt = '0;
          end
          if (rx_last_i) begin
            phase_nxt = RX_SERVICE;
            count_nxt = '0;
          end
        end else begin
          phase_nxt = RX_WAIT;
        end
      end
      RX_WAIT: begin
        if (rx_valid_i) begin
          store_en  = 1'b1;
          count_nxt = cnt_inc;
          phase_nxt = RX_RECEIVE;
        end
      end
      RX_SERVICE: begin
        count_nxt = '0;
        if (lat_service_r == trigger_service_i) begin
          req_nxt = 1'b1;
        end
        phase_nxt = RX_IDLE;
      end
      RX_PAYLOAD: begin
        store_en  = rx_valid_i;
        count_nxt = cnt_inc & IdxMask;
        if (rx_last_i) begin
          phase_nxt = RX_SERVICE;
          count_nxt = '0;
        end
      end
      default: begin
        phase_nxt = RX_IDLE;
        if (rx_valid_i) begin
          store_en  = 1'b1;
          count_nxt = cnt_inc;
          phase_nxt = RX_RECEIVE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= RX_IDLE;
      count_r <= '0;
      req_r   <= 1'b0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      req_r   <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i && store_en) begin
      case (idx)
        RxPosRoute:   sh_route_r   <= rx_flit_i;
        RxPosSize:    sh_size_r    <= rx_flit_i;
        RxPosService: sh_service_r <= rx_flit_i;
        RxPosTask:    sh_task_r    <= rx_flit_i;
        RxPosPeriph:  sh_periph_r  <= rx_flit_i;
        default: ;
      endcase
    end
    if (step_i && latch_en) begin
      lat_route_r   <= sh_route_r;
      lat_size_r    <= sh_size_r;
      lat_service_r <= sh_service_r;
      lat_task_r    <= sh_task_r;
      lat_periph_r  <= sh_periph_r;
    end
  end

  assign lat_o.route  = lat_route_r;
  assign lat_o.tsk    = lat_task_r;
  assign lat_o.periph = lat_periph_r;
  assign req_nxt_o    = req_nxt;

endmodule

FILE: rtl/snp_tx.sv
// Send side: tick counter, start window, forged header and payload sequencer with credit rewind.
// Depends on snp_pkg.
module snp_tx (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_i,
  input  logic          credit_i,
  input  snp_pkg::cfg_t cfg_i,
  input  snp_pkg::lat_t lat_i,
  output logic          valid_nxt_o,
  output logic [snp_pkg::FlitW-1:0] flit_nxt_o,
  output logic          last_nxt_o
);
  import snp_pkg::*;

  typedef enum logic [2:0] {
    TX_WAIT_REQ = 3'd0,
    TX_HEADER   = 3'd1,
    TX_PAYLOAD  = 3'd2,
    TX_WAIT_HDR = 3'd3,
    TX_WAIT_PAY = 3'd4,
    TX_EOP      = 3'd5
  } tx_phase_t;

  tx_phase_t        phase_r, phase_nxt;
  logic [5:0]       cnt_r, cnt_nxt, cnt_inc, cnt_back;
  logic [31:0]      tick_r, tick_nxt;
  logic [7:0]       gap_r, gap_nxt;
  logic [FlitW-1:0] flit_r, flit_nxt;
  logic             valid_r, valid_nxt, last_r, last_nxt;
  logic [FlitW-1:0] pk_task_r, pk_periph_r, pk_route_r;
  logic             pk_load, in_window;

  assign tick_nxt  = tick_r + 32'd1;
  assign in_window = (tick_nxt > cfg_i.window_start) && (tick_nxt < cfg_i.window_end);
  assign cnt_inc   = cnt_r + 6'd1;
  assign cnt_back  = (cnt_r >= 6'(RewindFlits)) ? cnt_r - 6'(RewindFlits) : '0;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    gap_nxt   = gap_r;
    flit_nxt  = flit_r;
    valid_nxt = valid_r;
    last_nxt  = last_r;
    pk_load   = 1'b0;
    case (phase_r)
      TX_HEADER: begin
        if (credit_i) begin
          flit_nxt = header_flit(cnt_r, cfg_i.forged_route, cfg_i.forged_service,
                                 pk_task_r, pk_periph_r, pk_route_r);
          cnt_nxt  = cnt_inc;
          if (cnt_inc == 6'(HeaderFlits)) begin
            phase_nxt = TX_PAYLOAD;
            cnt_nxt   = '0;
          end
        end else begin
          phase_nxt = TX_WAIT_HDR;
          valid_nxt = 1'b0;
        end
      end
      TX_PAYLOAD: begin
        if (credit_i) begin
          flit_nxt = payload_flit(cnt_r);
          cnt_nxt  = cnt_inc;
          if (cnt_inc == 6'(PayloadFlits)) begin
            phase_nxt = TX_EOP;
            last_nxt  = 1'b1;
            cnt_nxt   = '0;
          end
        end else begin
          phase_nxt = TX_WAIT_PAY;
          valid_nxt = 1'b0;
        end
      end
      TX_WAIT_HDR: begin
        if (credit_i) begin
          flit_nxt  = header_flit(cnt_back, cfg_i.forged_route, cfg_i.forged_service,
                                  pk_task_r, pk_periph_r, pk_route_r);
          valid_nxt = 1'b1;
          phase_nxt = TX_HEADER;
          cnt_nxt   = cnt_back + 6'd1;
        end
      end
      TX_WAIT_PAY: begin
        if (credit_i) begin
          flit_nxt  = payload_flit(cnt_back);
          valid_nxt = 1'b1;
          if (cnt_back == 6'(PayloadFlits)) begin
            phase_nxt = TX_EOP;
            last_nxt  = 1'b1;
            cnt_nxt   = cnt_back;
          end else begin
            phase_nxt = TX_PAYLOAD;
            cnt_nxt   = cnt_back + 6'd1;
          end
        end
      end
      TX_EOP: begin
        valid_nxt = 1'b0;
        last_nxt  = 1'b0;
        cnt_nxt   = '0;
        if (gap_r == cfg_i.gap_ticks) begin
          phase_nxt = TX_WAIT_REQ;
          gap_nxt   = 8'd1;
        end else begin
          gap_nxt   = gap_r + 8'd1;
        end
      end
      default: begin
        phase_nxt = TX_WAIT_REQ;
        if (in_window) begin
          pk_load   = 1'b1;
          flit_nxt  = cfg_i.forged_route;
          valid_nxt = 1'b1;
          if (credit_i) begin
            phase_nxt = TX_HEADER;
            cnt_nxt   = cnt_inc;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= TX_WAIT_REQ;
      cnt_r   <= '0;
      tick_r  <= '0;
      gap_r   <= '0;
      flit_r  <= '0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      tick_r  <= tick_nxt;
      gap_r   <= gap_nxt;
      flit_r  <= flit_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i && pk_load) begin
      pk_task_r   <= lat_i.tsk;
      pk_periph_r <= lat_i.periph;
      pk_route_r  <= lat_i.route;
    end
  end

  assign valid_nxt_o = valid_nxt;
  assign flit_nxt_o  = flit_nxt;
  assign last_nxt_o  = last_nxt;

endmodule

FILE: rtl/snp_skid.sv
// Two-word result buffer that decouples the result channel from the core.
// Depends on snp_pkg.
module snp_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  snp_pkg::res_t push_data_i,
  output logic          ready_o,
  output logic          out_valid_o,
  output snp_pkg::res_t out_data_o,
  input  logic          out_ready_i
);
  import snp_pkg::*;

  res_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign ready_o     = (fill_r != 2'd2);
  assign out_valid_o = (fill_r != 2'd0);
  assign out_data_o  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push_i && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push_i) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

FILE: tb/snoop_tb_pkg.sv
// Word-by-word predictor and result checker for the NoC snoop and inject block.
// Depends on snp_pkg for the result layout, register indexes and header constants.
package snoop_tb_pkg;
  import snp_pkg::*;

  typedef enum logic [2:0] {
    RX_IDLE, RX_TAKE, RX_HOLE, RX_CLOSE, RX_SKIP
  } rx_state_e;

  typedef enum logic [2:0] {
    TX_WINDOW, TX_HDR, TX_PAY, TX_HDR_STALL, TX_PAY_STALL, TX_END
  } tx_state_e;

  class port_tick_checker;
    cfg_t             regs;
    rx_state_e        rx_st;
    logic [7:0]       rx_cnt;
    logic [FlitW-1:0] shadow_route, shadow_size, shadow_svc, shadow_task, shadow_periph;
    logic [FlitW-1:0] held_route, held_size, held_svc, held_task, held_periph;
    logic             path_req;
    tx_state_e        tx_st;
    logic [5:0]       tx_cnt;
    logic [31:0]      ticks;
    logic [7:0]       gap_cnt;
    logic [FlitW-1:0] pk_task, pk_periph, pk_route;
    res_t             cur;
    res_t             forecast_words[$];
    int               errors;

    function new();
      regs.window_start    = 32'd33500;
      regs.window_end      = 32'd48000;
      regs.gap_ticks       = 8'd220;
      regs.trigger_service = 16'h0300;
      regs.forged_service  = 16'h0025;
      regs.forged_route    = 16'h0083;
      rx_st    = RX_IDLE;
      rx_cnt   = '0;
      path_req = 1'b0;
      tx_st    = TX_WINDOW;
      tx_cnt   = '0;
      ticks    = '0;
      gap_cnt  = '0;
      cur      = '0;
      errors   = 0;
      {shadow_route, shadow_size, shadow_svc, shadow_task, shadow_periph} = '0;
      {held_route, held_size, held_svc, held_task, held_periph} = '0;
      {pk_task, pk_periph, pk_route} = '0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [31:0] val);
      case (idx)
        CFG_WINDOW_START:    regs.window_start    = val;
        CFG_WINDOW_END:      regs.window_end      = val;
        CFG_GAP_TICKS:       regs.gap_ticks       = val[7:0];
        CFG_TRIGGER_SERVICE: regs.trigger_service = val[15:0];
        CFG_FORGED_SERVICE:  regs.forged_service  = val[15:0];
        CFG_FORGED_ROUTE:    regs.forged_route    = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [FlitW-1:0] forged_word(logic [5:0] pos);
      case (pos)
        TxPosRouteA, TxPosRouteB: return regs.forged_route;
        TxPosCtrlA, TxPosCtrlB:   return HdrCtrlWord;
        TxPosSize:                return HdrSizeWord;
        TxPosService:             return regs.forged_service;
        TxPosTask:                return pk_task;
        TxPosPeriph:              return pk_periph;
        TxPosRoute:               return pk_route;
        TxPosMark:                return HdrMarkWord;
        default:                  return '0;
      endcase
    endfunction

    function logic [FlitW-1:0] payload_word(logic [5:0] k);
      return FlitW'(HeaderFlits) + FlitW'(k);
    endfunction

    function void advance_sender(logic credit);
      ticks = ticks + 32'd1;
      case (tx_st)
        TX_HDR: begin
          if (credit) begin
            cur.tx_flit = forged_word(tx_cnt);
            tx_cnt = tx_cnt + 6'd1;
            if (tx_cnt == 6'(HeaderFlits)) begin
              tx_st = TX_PAY;
              tx_cnt = '0;
            end
          end else begin
            tx_st = TX_HDR_STALL;
            cur.tx_valid = 1'b0;
          end
        end
        TX_PAY: begin
          if (credit) begin
            cur.tx_flit = payload_word(tx_cnt);
            tx_cnt = tx_cnt + 6'd1;
            if (tx_cnt == 6'(PayloadFlits)) begin
              tx_st = TX_END;
              cur.tx_last = 1'b1;
              tx_cnt = '0;
            end
          end else begin
            tx_st = TX_PAY_STALL;
            cur.tx_valid = 1'b0;
          end
        end
        TX_HDR_STALL: begin
          if (credit) begin
            tx_cnt = (tx_cnt >= 6'(RewindFlits)) ? tx_cnt - 6'(RewindFlits) : '0;
            cur.tx_flit = forged_word(tx_cnt);
            cur.tx_valid = 1'b1;
            tx_st = TX_HDR;
            tx_cnt = tx_cnt + 6'd1;
          end
        end
        TX_PAY_STALL: begin
          if (credit) begin
            tx_cnt = (tx_cnt >= 6'(RewindFlits)) ? tx_cnt - 6'(RewindFlits) : '0;
            cur.tx_flit = payload_word(tx_cnt);
            cur.tx_valid = 1'b1;
            if (tx_cnt == 6'(PayloadFlits)) begin
              tx_st = TX_END;
              cur.tx_last = 1'b1;
            end else begin
              tx_cnt = tx_cnt + 6'd1;
              tx_st = TX_PAY;
            end
          end
        end
        TX_END: begin
          cur.tx_valid = 1'b0;
          cur.tx_last = 1'b0;
          tx_cnt = '0;
          if (gap_cnt == regs.gap_ticks) begin
            tx_st = TX_WINDOW;
            gap_cnt = '0;
          end
          gap_cnt = gap_cnt + 8'd1;
        end
        default: begin
          tx_st = TX_WINDOW;
          if (ticks > regs.window_start && ticks < regs.window_end) begin
            pk_task = held_task;
            pk_periph = held_periph;
            pk_route = held_route;
            cur.tx_flit = forged_word(TxPosRouteA);
            cur.tx_valid = 1'b1;
            if (credit) begin
              tx_st = TX_HDR;
              tx_cnt = tx_cnt + 6'd1;
            end
          end
        end
      endcase
    endfunction

    function void keep_flit(logic [FlitW-1:0] f);
      logic [6:0] idx;
      idx = 7'(int'(rx_cnt) % RxBufDepth);
      case (idx)
        RxPosRoute:   shadow_route  = f;
        RxPosSize:    shadow_size   = f;
        RxPosService: shadow_svc    = f;
        RxPosTask:    shadow_task   = f;
        RxPosPeriph:  shadow_periph = f;
        default: ;
      endcase
    endfunction

    function void advance_receiver(logic v, logic [FlitW-1:0] f, logic l);
      case (rx_st)
        RX_TAKE: begin
          if (v) begin
            keep_flit(f);
            rx_cnt = rx_cnt + 8'd1;
            if (rx_cnt == 8'(LatchCount)) begin
              held_route  = shadow_route;
              held_size   = shadow_size;
              held_svc    = shadow_svc;
              held_task   = shadow_task;
              held_periph = shadow_periph;
            end
            if (rx_cnt == 8'(HeaderFlits) && held_size > SizeSkipMin) begin
              rx_st = RX_SKIP;
              rx_cnt = '0;
            end
            if (l) begin
              rx_st = RX_CLOSE;
              rx_cnt = '0;
            end
          end else begin
            rx_st = RX_HOLE;
          end
        end
        RX_HOLE: begin
          if (v) begin
            keep_flit(f);
            rx_cnt = rx_cnt + 8'd1;
            rx_st = RX_TAKE;
          end
        end
        RX_CLOSE: begin
          rx_cnt = '0;
          if (held_svc == regs.trigger_service) path_req = 1'b1;
          rx_st = RX_IDLE;
        end
        RX_SKIP: begin
          if (v) keep_flit(f);
          rx_cnt = 8'((int'(rx_cnt) + 1) % RxBufDepth);
          if (l) begin
            rx_st = RX_CLOSE;
            rx_cnt = '0;
          end
        end
        default: begin
          rx_st = RX_IDLE;
          if (v) begin
            keep_flit(f);
            rx_cnt = rx_cnt + 8'd1;
            rx_st = RX_TAKE;
          end
        end
      endcase
    endfunction

    function void take_tick(logic [23:0] data, logic last);
      advance_sender(data[17]);
      advance_receiver(data[0], data[16:1], last);
      cur.path_request = path_req;
      forecast_words.push_back(cur);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", field, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [23:0] data, logic last);
      res_t want_word;
      if (forecast_words.size() == 0) begin
        $error("result word %h with no prediction pending", data);
        errors++;
        return;
      end
      want_word = forecast_words.pop_front();
      compare("tx_valid", 16'(want_word.tx_valid), 16'(data[0]));
      compare("tx_flit", want_word.tx_flit, data[16:1]);
      compare("tx_last", 16'(want_word.tx_last), 16'(last));
      compare("credit_out", 16'd1, 16'(data[17]));
      compare("path_request", 16'(want_word.path_request), 16'(data[18]));
      compare("zero fill", 16'd0, 16'(data[23:19]));
    endfunction

    function int pending();
      return forecast_words.size();
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench for noc_packet_snoop_and_inject: drives router ticks as stream words
// with directed and random snooped packets, credit loss and handshake stalls.
// Depends on snp_pkg and snoop_tb_pkg; every result word is checked against the predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import snp_pkg::*;
  import snoop_tb_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata   = '0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic                 out_tlast;
  logic                 cfg_we     = 1'b0;
  logic [CfgIndexW-1:0] cfg_index  = '0;
  logic [CfgDataW-1:0]  cfg_wdata  = '0;

  port_tick_checker sb;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          credit_drop_pct = 10;
  int          trig_pct = 0;
  logic [15:0] cur_trigger = 16'h0300;
  bit          hold_go = 1'b0;
  int          hold_left = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;

  noc_packet_snoop_and_inject DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 300;
    end
    if (!rst_n || hold_left > 0) begin
      out_tready <= 1'b0;
      if (hold_left > 0) hold_left = hold_left - 1;
    end else if (recv_stall_pct == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Values are stable between the falling edge and the next rising edge, so a word seen
  // with valid and ready here is the one taken at that rising edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.take_tick(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast);
    end
  end

  function automatic logic credit_draw();
    return $urandom_range(99) >= credit_drop_pct;
  endfunction

  task automatic put_word(logic rv, logic [15:0] rf, logic rl, logic cr);
    logic ok;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, cr, rf, rv};
    in_tlast  <= rl;
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [31:0] wstart, logic [31:0] wend, logic [7:0] gap,
                           logic [15:0] trig, logic [15:0] fsvc, logic [15:0] froute);
    write_reg(CFG_WINDOW_START, wstart);
    write_reg(CFG_WINDOW_END, wend);
    write_reg(CFG_GAP_TICKS, 32'(gap));
    write_reg(CFG_TRIGGER_SERVICE, 32'(trig));
    write_reg(CFG_FORGED_SERVICE, 32'(fsvc));
    write_reg(CFG_FORGED_ROUTE, 32'(froute));
    cfg_we <= 1'b0;
    cur_trigger = trig;
  endtask

  // Header words land at their receive positions; with holes, idle ticks are slipped in.
  task automatic snoop_packet(logic [15:0] route, logic [15:0] size, logic [15:0] svc,
                              logic [15:0] tsk, logic [15:0] periph, int unsigned len,
                              bit holes);
    logic [15:0] f;
    logic        rv;
    for (int unsigned i = 0; i < len; i++) begin
      if (holes && $urandom_range(15) == 0)
        put_word(1'b0, 16'($urandom), $urandom_range(3) == 0, credit_draw());
      case (7'(i))
        RxPosRoute:   f = route;
        RxPosSize:    f = size;
        RxPosService: f = svc;
        RxPosTask:    f = tsk;
        RxPosPeriph:  f = periph;
        default:      f = 16'($urandom);
      endcase
      rv = (i + 1 == len && len > HeaderFlits && size > SizeSkipMin) ? 1'($urandom) : 1'b1;
      put_word(rv, f, i + 1 == len, credit_draw());
    end
    if ($urandom_range(3) != 0) put_word(1'b0, '0, 1'b0, credit_draw());
  endtask

  task automatic random_packet();
    logic [15:0] size;
    logic [15:0] svc;
    int unsigned len;
    case ($urandom_range(3))
      0: size = 16'($urandom_range(11));
      1: size = 16'($urandom_range(65535, 12));
      2: size = $urandom_range(1) ? SizeSkipMin : SizeSkipMin + 16'd1;
      default: size = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
    svc = ($urandom_range(99) < trig_pct) ? cur_trigger : 16'($urandom);
    if ($urandom_range(59) == 0) len = $urandom_range(280, 260);
    else if (size > SizeSkipMin) len = $urandom_range(36, HeaderFlits);
    else len = $urandom_range(34, 10);
    snoop_packet(16'($urandom), size, svc, 16'($urandom), 16'($urandom), len,
                 $urandom_range(3) == 0);
  endtask

  task automatic line_noise();
    repeat ($urandom_range(6, 1))
      put_word(1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [11:0] credit_seq;
    int unsigned target;
    int unsigned midway;
    bit          paused;
    sb = new();
    credit_seq = 12'b1011_1110_1010;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // The header latch must be filled before any packet is forged or closed.
    snoop_packet(16'hFFFF, SizeSkipMin, 16'h0000, 16'hAAAA, 16'h5555, LatchCount, 1'b0);
    put_word(1'b0, 16'h0000, 1'b1, 1'b0);
    drain();
    configure(32'd0, 32'hFFFF_FFFF, 8'd1, 16'h1234, 16'hFFFF, 16'h0000);
    for (int i = 0; i < 12; i++)
      put_word(1'(i), 16'hFFFF, 1'b1, credit_seq[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0; recv_stall_pct = 0; trig_pct = 0;
          configure(32'd0, 32'hFFFF_FFFF, 8'd1, 16'($urandom), 16'($urandom),
                    16'($urandom));
          hold_go = 1'b1;
        end
        1: begin
          send_idle_pct = 64; recv_stall_pct = 0; trig_pct = 4;
          configure(sb.ticks + 32'd40, sb.ticks + 32'd400, 8'd255, 16'($urandom),
                    16'h0000, 16'hFFFF);
        end
        2: begin
          send_idle_pct = 0; recv_stall_pct = 64; trig_pct = 4;
          configure(32'hFFFF_FFFF, 32'd0, 8'($urandom_range(255, 1)), 16'($urandom),
                    16'($urandom), 16'($urandom));
        end
        default: begin
          send_idle_pct = 6; recv_stall_pct = 6; trig_pct = 4;
          configure(sb.ticks, sb.ticks + 32'($urandom_range(2000, 200)),
                    8'($urandom_range(255, 1)), 16'($urandom), 16'($urandom),
                    16'($urandom));
        end
      endcase
      target = words_sent + 320;
      midway = words_sent + 160;
      paused = 1'b0;
      while (words_sent < target) begin
        if (!paused && words_sent >= midway) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(6) == 0) line_noise();
        else random_packet();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
